// ===== rtl/core/selt_pkg.sv =====
package selt_pkg;

	// Request codes
	localparam logic [2:0] REQ_ADD     = 3'd0;
	localparam logic [2:0] REQ_SWITCH  = 3'd1;
	localparam logic [2:0] REQ_REMOVE  = 3'd2;
	localparam logic [2:0] REQ_SUSPEND = 3'd3;
	localparam logic [2:0] REQ_RESUME  = 3'd4;
	localparam logic [2:0] REQ_CHECK   = 3'd5;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_INVALID    = 3'd1,
		ST_FULL       = 3'd2,
		ST_NOT_FOUND  = 3'd3,
		ST_IS_CURRENT = 3'd4
	} status_t;

	// Configuration register indexes
	localparam logic CFG_THRESHOLD = 1'b0;
	localparam logic CFG_MAX_SUSP  = 1'b1;

	localparam logic [23:0] THRESHOLD_RESET = 24'd65536;
	localparam logic [4:0]  MAX_SUSP_RESET  = 5'd3;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_FLAG,
		OP_SHIFT,
		OP_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic        susp;
		logic        stamp;
		logic [15:0] key;
		logic [15:0] id;
		logic [31:0] handle;
		logic [31:0] time_val;
	} cell_cmd_t;

endpackage

// ===== rtl/core/suspended_entry_lru_table_unit.sv =====
// Compacted table of up to MAX_ENTRIES entries held in a chain of cells, one entry per cell.
// Id lookup is a parallel compare across the chain. One request is in work at a time. Add,
// remove, suspend and resume go from the lookup state S_LOOK to S_FIN, which loads the result
// into the output register. Switch passes through S_SW2 between them for its second flag update.
// A memory check that finds heap_avail below the threshold (on request, or after an add of a
// new id) rotates the whole chain once past a single compare stage at cell 0, then goes
// through S_EVICT for the eviction.
// A finished result sits in the output register while the next request is taken. While that
// result is stalled, the next request holds in its last cycle and no new transfer in is taken.
module suspended_entry_lru_table_unit #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     req_type,
	input  logic [15:0]                    entry_id,
	input  logic [31:0]                    handle_in,
	input  logic [23:0]                    heap_avail,
	input  logic [31:0]                    now,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     status,
	output logic [31:0]                    handle_out,
	output logic                           evicted,
	output logic [15:0]                    evicted_id,
	output logic [31:0]                    evicted_handle,
	output logic [$clog2(MAX_ENTRIES+1)-1:0] entry_count,
	input  logic                           cfg_wr_en,
	input  logic                           cfg_index,
	input  logic [23:0]                    cfg_wdata
);

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int SW = (CW > 5) ? CW : 5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_SW2,
		S_SCAN,
		S_EVICT,
		S_FIN
	} state_t;

	state_t state_q;
	state_t look_nxt;

	// configuration
	logic [23:0] thr_q;
	logic [4:0]  max_susp_q;

	// request
	logic [2:0]  req_q;
	logic [15:0] id_q;
	logic [31:0] hin_q;
	logic [23:0] heap_q;
	logic [31:0] now_q;

	// table control
	logic [CW-1:0] count_q;
	logic          cur_valid_q;
	logic [IW-1:0] cur_slot_q;
	logic [IW-1:0] tgt_q;

	// scan
	logic [IW-1:0] scan_q;
	logic [CW-1:0] nsusp_q;
	logic [31:0]   oldest_q;
	logic          pick_valid_q;
	logic [IW-1:0] pick_q;
	logic [15:0]   pick_id_q;
	logic [31:0]   pick_handle_q;

	// staged result
	selt_pkg::status_t res_status_q;
	logic [31:0]       res_handle_q;
	logic              res_evicted_q;
	logic [15:0]       res_ev_id_q;
	logic [31:0]       res_ev_handle_q;

	// output register
	logic              out_valid_q;
	selt_pkg::status_t status_q;
	logic [31:0]       handle_out_q;
	logic              evicted_q;
	logic [15:0]       evicted_id_q;
	logic [31:0]       evicted_handle_q;
	logic [CW-1:0]     entry_count_q;

	// chain
	selt_pkg::cell_cmd_t cmd;
	logic [IW-1:0]       cmd_slot;
	logic [15:0]         ent_id     [MAX_ENTRIES];
	logic [31:0]         ent_handle [MAX_ENTRIES];
	logic                ent_susp   [MAX_ENTRIES];
	logic [31:0]         ent_time   [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] ent_match;

	logic          hit;
	logic [IW-1:0] hit_idx;
	logic [31:0]   hit_handle;
	logic          hit_is_cur;
	logic          heap_low;
	logic          evict_go;
	logic          scan_in_range;
	logic          scan_is_cur;

	genvar g;
	generate
		for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
			localparam int NXT = (g + 1) % MAX_ENTRIES;
			selt_cell #(
				.IW  (IW),
				.IDX (g)
			) u_cell (
				.clk         (clk),
				.cmd         (cmd),
				.slot        (cmd_slot),
				.nxt_id      (ent_id[NXT]),
				.nxt_handle  (ent_handle[NXT]),
				.nxt_susp    (ent_susp[NXT]),
				.nxt_time    (ent_time[NXT]),
				.id          (ent_id[g]),
				.handle      (ent_handle[g]),
				.susp        (ent_susp[g]),
				.access_time (ent_time[g]),
				.match       (ent_match[g])
			);
		end
	endgenerate

	// ids are unique among live entries, so the live match vector is one-hot
	always_comb begin
		hit        = 1'b0;
		hit_idx    = '0;
		hit_handle = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (ent_match[i] && (CW'(i) < count_q)) begin
				hit        = 1'b1;
				hit_idx    = hit_idx | IW'(i);
				hit_handle = hit_handle | ent_handle[i];
			end
		end
	end

	assign hit_is_cur    = cur_valid_q && (cur_slot_q == hit_idx);
	assign heap_low      = (heap_q < thr_q);
	assign evict_go      = pick_valid_q && (SW'(nsusp_q) >= SW'(max_susp_q));
	assign scan_in_range = (CW'(scan_q) < count_q);
	assign scan_is_cur   = cur_valid_q && (cur_slot_q == scan_q);

	// where the lookup cycle goes next
	always_comb begin
		look_nxt = S_FIN;
		case (req_q)
			selt_pkg::REQ_ADD: begin
				if ((hin_q != '0) && (count_q != CW'(MAX_ENTRIES)) && !hit && heap_low) begin
					look_nxt = S_SCAN;
				end
			end
			selt_pkg::REQ_SWITCH: begin
				if (hit) begin
					look_nxt = S_SW2;
				end
			end
			selt_pkg::REQ_CHECK: begin
				if (heap_low) begin
					look_nxt = S_SCAN;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cmd.op       = selt_pkg::OP_NOP;
		cmd.susp     = 1'b0;
		cmd.stamp    = 1'b0;
		cmd.key      = id_q;
		cmd.id       = id_q;
		cmd.handle   = hin_q;
		cmd.time_val = now_q;
		cmd_slot     = '0;
		unique case (state_q)
			S_LOOK: begin
				case (req_q)
					selt_pkg::REQ_ADD: begin
						if ((hin_q != '0) && (count_q != CW'(MAX_ENTRIES))) begin
							cmd.op   = selt_pkg::OP_LOAD;
							cmd_slot = hit ? hit_idx : count_q[IW-1:0];
						end
					end
					selt_pkg::REQ_SWITCH: begin
						// suspend the previous current entry first
						if (hit && cur_valid_q && (cur_slot_q != hit_idx)) begin
							cmd.op    = selt_pkg::OP_FLAG;
							cmd.susp  = 1'b1;
							cmd.stamp = 1'b1;
							cmd_slot  = cur_slot_q;
						end
					end
					selt_pkg::REQ_REMOVE: begin
						if (hit) begin
							cmd.op   = selt_pkg::OP_SHIFT;
							cmd_slot = hit_idx;
						end
					end
					selt_pkg::REQ_SUSPEND: begin
						if (hit && !hit_is_cur) begin
							cmd.op   = selt_pkg::OP_FLAG;
							cmd.susp = 1'b1;
							cmd_slot = hit_idx;
						end
					end
					selt_pkg::REQ_RESUME: begin
						if (hit) begin
							cmd.op   = selt_pkg::OP_FLAG;
							cmd_slot = hit_idx;
						end
					end
					default: begin
					end
				endcase
			end
			S_SW2: begin
				cmd.op    = selt_pkg::OP_FLAG;
				cmd.stamp = 1'b1;
				cmd_slot  = tgt_q;
			end
			S_SCAN: begin
				cmd.op = selt_pkg::OP_ROT;
			end
			S_EVICT: begin
				if (evict_go) begin
					cmd.op   = selt_pkg::OP_SHIFT;
					cmd_slot = pick_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= selt_pkg::THRESHOLD_RESET;
			max_susp_q <= selt_pkg::MAX_SUSP_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				selt_pkg::CFG_THRESHOLD: thr_q      <= cfg_wdata;
				selt_pkg::CFG_MAX_SUSP:  max_susp_q <= cfg_wdata[4:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cur_valid_q <= 1'b0;
			cur_slot_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q           <= req_type;
						id_q            <= entry_id;
						hin_q           <= handle_in;
						heap_q          <= heap_avail;
						now_q           <= now;
						res_status_q    <= selt_pkg::ST_OK;
						res_handle_q    <= '0;
						res_evicted_q   <= 1'b0;
						res_ev_id_q     <= '0;
						res_ev_handle_q <= '0;
						state_q         <= S_LOOK;
					end
				end
				S_LOOK: begin
					scan_q       <= '0;
					nsusp_q      <= '0;
					oldest_q     <= now_q;
					pick_valid_q <= 1'b0;
					state_q      <= look_nxt;
					case (req_q)
						selt_pkg::REQ_ADD: begin
							if (hin_q == '0) begin
								res_status_q <= selt_pkg::ST_INVALID;
							end else if (count_q == CW'(MAX_ENTRIES)) begin
								res_status_q <= selt_pkg::ST_FULL;
							end else if (!hit) begin
								count_q <= count_q + CW'(1);
							end
						end
						selt_pkg::REQ_SWITCH: begin
							if (!hit) begin
								res_status_q <= selt_pkg::ST_NOT_FOUND;
							end else begin
								res_handle_q <= hit_handle;
								tgt_q        <= hit_idx;
							end
						end
						selt_pkg::REQ_REMOVE: begin
							if (!hit) begin
								res_status_q <= selt_pkg::ST_NOT_FOUND;
							end else begin
								res_handle_q <= hit_handle;
								count_q      <= count_q - CW'(1);
								if (cur_valid_q) begin
									if (cur_slot_q == hit_idx) begin
										cur_valid_q <= 1'b0;
										cur_slot_q  <= '0;
									end else if (cur_slot_q > hit_idx) begin
										cur_slot_q <= cur_slot_q - IW'(1);
									end
								end
							end
						end
						selt_pkg::REQ_SUSPEND: begin
							if (!hit) begin
								res_status_q <= selt_pkg::ST_NOT_FOUND;
							end else if (hit_is_cur) begin
								res_status_q <= selt_pkg::ST_IS_CURRENT;
							end
						end
						selt_pkg::REQ_RESUME: begin
							if (!hit) begin
								res_status_q <= selt_pkg::ST_NOT_FOUND;
							end
						end
						selt_pkg::REQ_CHECK: begin
						end
						default: begin
							res_status_q <= selt_pkg::ST_INVALID;
						end
					endcase
				end
				S_SW2: begin
					cur_valid_q <= 1'b1;
					cur_slot_q  <= tgt_q;
					state_q     <= S_FIN;
				end
				S_SCAN: begin
					// cell 0 holds the entry of slot scan_q during this cycle
					if (scan_in_range && ent_susp[0]) begin
						nsusp_q <= nsusp_q + CW'(1);
						if (!scan_is_cur && (ent_time[0] < oldest_q)) begin
							oldest_q      <= ent_time[0];
							pick_valid_q  <= 1'b1;
							pick_q        <= scan_q;
							pick_id_q     <= ent_id[0];
							pick_handle_q <= ent_handle[0];
						end
					end
					scan_q <= scan_q + IW'(1);
					if (scan_q == IW'(MAX_ENTRIES - 1)) begin
						state_q <= S_EVICT;
					end
				end
				S_EVICT: begin
					if (evict_go) begin
						res_evicted_q   <= 1'b1;
						res_ev_id_q     <= pick_id_q;
						res_ev_handle_q <= pick_handle_q;
						count_q         <= count_q - CW'(1);
						if (cur_valid_q) begin
							if (cur_slot_q == pick_q) begin
								cur_valid_q <= 1'b0;
								cur_slot_q  <= '0;
							end else if (cur_slot_q > pick_q) begin
								cur_slot_q <= cur_slot_q - IW'(1);
							end
						end
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q      <= 1'b1;
						status_q         <= res_status_q;
						handle_out_q     <= res_handle_q;
						evicted_q        <= res_evicted_q;
						evicted_id_q     <= res_ev_id_q;
						evicted_handle_q <= res_ev_handle_q;
						entry_count_q    <= count_q;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign handle_out     = handle_out_q;
	assign evicted        = evicted_q;
	assign evicted_id     = evicted_id_q;
	assign evicted_handle = evicted_handle_q;
	assign entry_count    = entry_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count exceeds table depth");

	a_cur_live: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (CW'(cur_slot_q) < count_q))
		else $error("current slot points past the live entries");

	a_evict_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && evicted_q) |-> (status_q == selt_pkg::ST_OK))
		else $error("eviction reported with a failing status");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && scan_q == IW'(MAX_ENTRIES - 1)) |=> (state_q == S_EVICT))
		else $error("scan did not end after a full rotation");

endmodule

// ===== rtl/core/selt_cell.sv =====
module selt_cell #(
	parameter int IW  = 4,
	parameter int IDX = 0
) (
	input  logic                clk,
	input  selt_pkg::cell_cmd_t cmd,
	input  logic [IW-1:0]       slot,
	input  logic [15:0]         nxt_id,
	input  logic [31:0]         nxt_handle,
	input  logic                nxt_susp,
	input  logic [31:0]         nxt_time,
	output logic [15:0]         id,
	output logic [31:0]         handle,
	output logic                susp,
	output logic [31:0]         access_time,
	output logic                match
);

	logic [15:0] id_q;
	logic [31:0] handle_q;
	logic        susp_q;
	logic [31:0] time_q;
	logic        sel;
	logic        upper;

	assign sel   = (slot == IW'(IDX));
	assign upper = (IW'(IDX) >= slot);

	always_ff @(posedge clk) begin
		case (cmd.op)
			selt_pkg::OP_LOAD: begin
				if (sel) begin
					id_q     <= cmd.id;
					handle_q <= cmd.handle;
					susp_q   <= 1'b0;
					time_q   <= cmd.time_val;
				end
			end
			selt_pkg::OP_FLAG: begin
				if (sel) begin
					susp_q <= cmd.susp;
					if (cmd.stamp) begin
						time_q <= cmd.time_val;
					end
				end
			end
			selt_pkg::OP_SHIFT: begin
				// close the gap: every entry at or above the slot takes its neighbor
				if (upper) begin
					id_q     <= nxt_id;
					handle_q <= nxt_handle;
					susp_q   <= nxt_susp;
					time_q   <= nxt_time;
				end
			end
			selt_pkg::OP_ROT: begin
				id_q     <= nxt_id;
				handle_q <= nxt_handle;
				susp_q   <= nxt_susp;
				time_q   <= nxt_time;
			end
			default: begin
			end
		endcase
	end

	assign id          = id_q;
	assign handle      = handle_q;
	assign susp        = susp_q;
	assign access_time = time_q;
	assign match       = (id_q == cmd.key);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int DEPTH = 16;
	localparam int SETTLE_CYCLES = DEPTH + 8;
	localparam int POOL_SIZE = 24;
	localparam logic [2:0] REQ_RSVD6 = 3'd6;
	localparam logic [2:0] REQ_RSVD7 = 3'd7;

	localparam int GAP_NONE = 0;
	localparam int GAP_LIGHT = 1;
	localparam int GAP_HEAVY = 2;

	typedef struct {
		selt_pkg::status_t status;
		logic [31:0] handle;
		logic        evicted;
		logic [15:0] evicted_id;
		logic [31:0] evicted_handle;
		logic [4:0]  count;
	} table_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  req_type = '0;
	logic [15:0] entry_id = '0;
	logic [31:0] handle_in = '0;
	logic [23:0] heap_avail = '0;
	logic [31:0] now = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [31:0] handle_out;
	logic        evicted;
	logic [15:0] evicted_id;
	logic [31:0] evicted_handle;
	logic [4:0]  entry_count;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_index = 1'b0;
	logic [23:0] cfg_wdata = '0;

	// Shadow copy of the table
	logic [15:0] tbl_id [DEPTH];
	logic [31:0] tbl_handle [DEPTH];
	logic        tbl_susp [DEPTH];
	logic [31:0] tbl_stamp [DEPTH];
	int          tbl_count;
	bit          cur_valid;
	int          cur_slot;
	logic [23:0] cfg_threshold;
	logic [4:0]  cfg_max_susp;

	table_result_t pending_results[$];
	int errors = 0;
	int tx_gap_mode = GAP_NONE;
	int rx_stall_mode = GAP_NONE;
	int rx_hold = 0;
	int rx_left = 0;
	logic [15:0] id_pool [POOL_SIZE];
	logic [31:0] tick = '0;

	suspended_entry_lru_table_unit #(.MAX_ENTRIES(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.entry_id(entry_id),
		.handle_in(handle_in),
		.heap_avail(heap_avail),
		.now(now),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.handle_out(handle_out),
		.evicted(evicted),
		.evicted_id(evicted_id),
		.evicted_handle(evicted_handle),
		.entry_count(entry_count),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic int find_slot(input logic [15:0] id);
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_id[i] == id) return i;
		end
		return -1;
	endfunction

	function automatic void drop_entry(input int slot);
		for (int i = slot; i + 1 < tbl_count; i++) begin
			tbl_id[i] = tbl_id[i + 1];
			tbl_handle[i] = tbl_handle[i + 1];
			tbl_susp[i] = tbl_susp[i + 1];
			tbl_stamp[i] = tbl_stamp[i + 1];
		end
		tbl_count--;
		if (cur_valid) begin
			if (cur_slot == slot) begin
				cur_valid = 1'b0;
				cur_slot = 0;
			end else if (cur_slot > slot) begin
				cur_slot--;
			end
		end
	endfunction

	// Evict the oldest suspended, non-current entry stamped strictly before t
	function automatic void evict_lru(input logic [23:0] heap, input logic [31:0] t,
			inout table_result_t r);
		int nsusp;
		int pick;
		logic [31:0] oldest;
		nsusp = 0;
		pick = -1;
		oldest = t;
		if (heap >= cfg_threshold) return;
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_susp[i]) nsusp++;
		end
		if (nsusp < int'(cfg_max_susp)) return;
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_susp[i] && !(cur_valid && cur_slot == i) && tbl_stamp[i] < oldest) begin
				oldest = tbl_stamp[i];
				pick = i;
			end
		end
		if (pick >= 0) begin
			r.evicted = 1'b1;
			r.evicted_id = tbl_id[pick];
			r.evicted_handle = tbl_handle[pick];
			drop_entry(pick);
		end
	endfunction

	function automatic table_result_t table_update(input logic [2:0] req, input logic [15:0] id,
			input logic [31:0] hin, input logic [23:0] heap, input logic [31:0] t);
		table_result_t r;
		int slot;
		r.status = selt_pkg::ST_OK;
		r.handle = '0;
		r.evicted = 1'b0;
		r.evicted_id = '0;
		r.evicted_handle = '0;
		case (req)
			selt_pkg::REQ_ADD: begin
				if (hin == '0) begin
					r.status = selt_pkg::ST_INVALID;
				end else if (tbl_count >= DEPTH) begin
					r.status = selt_pkg::ST_FULL;
				end else begin
					slot = find_slot(id);
					if (slot >= 0) begin
						tbl_handle[slot] = hin;
						tbl_stamp[slot] = t;
						tbl_susp[slot] = 1'b0;
					end else begin
						tbl_id[tbl_count] = id;
						tbl_handle[tbl_count] = hin;
						tbl_susp[tbl_count] = 1'b0;
						tbl_stamp[tbl_count] = t;
						tbl_count++;
						evict_lru(heap, t, r);
					end
				end
			end
			selt_pkg::REQ_SWITCH: begin
				slot = find_slot(id);
				if (slot < 0) begin
					r.status = selt_pkg::ST_NOT_FOUND;
				end else begin
					// the entry we leave is parked and stamped
					if (cur_valid && cur_slot != slot) begin
						tbl_susp[cur_slot] = 1'b1;
						tbl_stamp[cur_slot] = t;
					end
					cur_valid = 1'b1;
					cur_slot = slot;
					tbl_susp[slot] = 1'b0;
					tbl_stamp[slot] = t;
					r.handle = tbl_handle[slot];
				end
			end
			selt_pkg::REQ_REMOVE: begin
				slot = find_slot(id);
				if (slot < 0) begin
					r.status = selt_pkg::ST_NOT_FOUND;
				end else begin
					r.handle = tbl_handle[slot];
					drop_entry(slot);
				end
			end
			selt_pkg::REQ_SUSPEND: begin
				slot = find_slot(id);
				if (slot < 0) r.status = selt_pkg::ST_NOT_FOUND;
				else if (cur_valid && cur_slot == slot) r.status = selt_pkg::ST_IS_CURRENT;
				else tbl_susp[slot] = 1'b1;
			end
			selt_pkg::REQ_RESUME: begin
				slot = find_slot(id);
				if (slot < 0) r.status = selt_pkg::ST_NOT_FOUND;
				else tbl_susp[slot] = 1'b0;
			end
			selt_pkg::REQ_CHECK: evict_lru(heap, t, r);
			default: r.status = selt_pkg::ST_INVALID;
		endcase
		r.count = tbl_count[4:0];
		return r;
	endfunction

	function automatic int pick_gap(input int mode);
		int r;
		r = $urandom_range(0, 99);
		if (mode == GAP_NONE) return 0;
		if (mode == GAP_LIGHT) begin
			if (r < 65) return 0;
			if (r < 93) return $urandom_range(1, 3);
			return $urandom_range(8, 40);
		end
		if (r < 30) return 0;
		if (r < 80) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [23:0] rand_heap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 24'($urandom_range(0, cfg_threshold));
		if (r < 52) return cfg_threshold;
		if (r < 55) return cfg_threshold - 24'd1;
		return 24'($urandom);
	endfunction

	function automatic void advance_tick();
		if ($urandom_range(0, 49) == 0) tick = $urandom;
		else tick = tick + 32'($urandom_range(0, 3));
	endfunction

	function automatic void report_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			errors++;
		end
	endfunction

	// Result checker and receiver stall generator
	always @(posedge clk) begin : rx_side
		table_result_t want;
		int n;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no pending request");
				errors++;
			end else begin
				want = pending_results.pop_front();
				report_field("status", 32'(want.status), 32'(status));
				report_field("handle_out", want.handle, handle_out);
				report_field("evicted", 32'(want.evicted), 32'(evicted));
				report_field("evicted_id", 32'(want.evicted_id), 32'(evicted_id));
				report_field("evicted_handle", want.evicted_handle, evicted_handle);
				report_field("entry_count", 32'(want.count), 32'(entry_count));
			end
		end
		if (rx_hold > 0) begin
			rx_hold--;
			out_stall <= 1'b1;
		end else if (rx_left > 0) begin
			rx_left--;
			out_stall <= 1'b1;
		end else begin
			n = pick_gap(rx_stall_mode);
			rx_left = (n > 0) ? n - 1 : 0;
			out_stall <= (n > 0);
		end
	end

	task automatic send_req(input logic [2:0] req, input logic [15:0] id, input logic [31:0] hin,
			input logic [23:0] heap, input logic [31:0] t);
		int gap;
		gap = pick_gap(tx_gap_mode);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		entry_id <= id;
		handle_in <= hin;
		heap_avail <= heap;
		now <= t;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(table_update(req, id, hin, heap, t));
	endtask

	task automatic send_random_req();
		int r;
		logic [2:0] req;
		logic [15:0] id;
		logic [31:0] hin;
		r = $urandom_range(0, 99);
		if (r < 28) req = selt_pkg::REQ_ADD;
		else if (r < 46) req = selt_pkg::REQ_SWITCH;
		else if (r < 56) req = selt_pkg::REQ_REMOVE;
		else if (r < 72) req = selt_pkg::REQ_SUSPEND;
		else if (r < 80) req = selt_pkg::REQ_RESUME;
		else if (r < 97) req = selt_pkg::REQ_CHECK;
		else if (r < 99) req = REQ_RSVD6;
		else req = REQ_RSVD7;
		if ($urandom_range(0, 19) == 0) id = 16'($urandom);
		else id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
		hin = ($urandom_range(0, 31) == 0) ? 32'd0 : $urandom;
		advance_tick();
		send_req(req, id, hin, rand_heap(), tick);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [23:0] thr, input logic [4:0] max_susp);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= selt_pkg::CFG_THRESHOLD;
		cfg_wdata <= thr;
		@(posedge clk);
		cfg_index <= selt_pkg::CFG_MAX_SUSP;
		cfg_wdata <= {19'd0, max_susp};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		cfg_threshold = thr;
		cfg_max_susp = max_susp;
	endtask

	task automatic test_directed();
		tx_gap_mode = GAP_LIGHT;
		rx_stall_mode = GAP_LIGHT;
		send_req(REQ_RSVD6, 16'h1234, 32'd1, 24'h000000, 32'd0);
		send_req(REQ_RSVD7, 16'hFFFF, 32'hFFFF_FFFF, 24'hFFFFFF, 32'hFFFF_FFFF);
		send_req(selt_pkg::REQ_ADD, 16'h0005, 32'd0, 24'hFFFFFF, 32'd5);
		send_req(selt_pkg::REQ_ADD, 16'h0000, 32'hFFFF_FFFF, 24'hFFFFFF, 32'd10);
		send_req(selt_pkg::REQ_ADD, 16'hFFFF, 32'd1, 24'hFFFFFF, 32'd11);
		// existing id: refresh in place
		send_req(selt_pkg::REQ_ADD, 16'h0000, 32'd2, 24'h000000, 32'd12);
		send_req(selt_pkg::REQ_SWITCH, 16'h1234, 32'd0, 24'hFFFFFF, 32'd13);
		send_req(selt_pkg::REQ_SWITCH, 16'h0000, 32'd0, 24'hFFFFFF, 32'd20);
		send_req(selt_pkg::REQ_SWITCH, 16'hFFFF, 32'd0, 24'hFFFFFF, 32'd21);
		send_req(selt_pkg::REQ_SUSPEND, 16'hFFFF, 32'd0, 24'hFFFFFF, 32'd22);
		send_req(selt_pkg::REQ_SUSPEND, 16'h0777, 32'd0, 24'hFFFFFF, 32'd23);
		send_req(selt_pkg::REQ_RESUME, 16'h0000, 32'd0, 24'hFFFFFF, 32'd24);
		send_req(selt_pkg::REQ_RESUME, 16'h0999, 32'd0, 24'hFFFFFF, 32'd25);
		send_req(selt_pkg::REQ_ADD, 16'h00AA, 32'hAAAA_AAAA, 24'hFFFFFF, 32'd30);
		send_req(selt_pkg::REQ_ADD, 16'h5555, 32'h5555_5555, 24'hFFFFFF, 32'd31);
		send_req(selt_pkg::REQ_SUSPEND, 16'h00AA, 32'd0, 24'hFFFFFF, 32'd32);
		send_req(selt_pkg::REQ_SUSPEND, 16'h5555, 32'd0, 24'hFFFFFF, 32'd33);
		send_req(selt_pkg::REQ_SUSPEND, 16'h0000, 32'd0, 24'hFFFFFF, 32'd34);
		send_req(selt_pkg::REQ_CHECK, 16'h0000, 32'd0, 24'h000000, 32'd40);
		send_req(selt_pkg::REQ_CHECK, 16'h0000, 32'd0,
			selt_pkg::THRESHOLD_RESET - 24'd1, 32'd41);
		send_req(selt_pkg::REQ_REMOVE, 16'hFFFF, 32'd0, 24'hFFFFFF, 32'd42);
		send_req(selt_pkg::REQ_REMOVE, 16'h1111, 32'd0, 24'hFFFFFF, 32'd43);
		send_req(selt_pkg::REQ_SWITCH, 16'h5555, 32'd0, 24'hFFFFFF, 32'd50);
		// removal below the current entry shifts it down
		send_req(selt_pkg::REQ_REMOVE, 16'h00AA, 32'd0, 24'hFFFFFF, 32'd51);
		send_req(selt_pkg::REQ_SUSPEND, 16'h5555, 32'd0, 24'hFFFFFF, 32'd52);
		send_req(selt_pkg::REQ_CHECK, 16'h5555, 32'd0,
			selt_pkg::THRESHOLD_RESET, 32'hFFFF_FFFF);
	endtask

	task automatic test_capacity();
		tx_gap_mode = GAP_NONE;
		rx_stall_mode = GAP_NONE;
		set_config(24'd0, 5'd16);
		send_req(selt_pkg::REQ_REMOVE, 16'h5555, 32'd0, 24'd0, 32'd99);
		// same stamp everywhere so evictions tie and the lowest slot goes first
		for (int i = 0; i < DEPTH + 1; i++)
			send_req(selt_pkg::REQ_ADD, 16'h0100 + 16'(i), $urandom | 32'd1, 24'd0, 32'd100);
		send_req(selt_pkg::REQ_ADD, 16'h0100, 32'd7, 24'd0, 32'd100);
		send_req(selt_pkg::REQ_ADD, 16'h0200, 32'd0, 24'd0, 32'd100);
		for (int i = 0; i < DEPTH; i++)
			send_req(selt_pkg::REQ_SUSPEND, tbl_id[i], 32'd0, 24'd0, 32'd100);
		set_config(24'hFFFFFF, 5'd16);
		send_req(selt_pkg::REQ_CHECK, 16'd0, 32'd0, 24'hFFFFFF, 32'd101);
		send_req(selt_pkg::REQ_CHECK, 16'd0, 32'd0, 24'd0, 32'd101);
		send_req(selt_pkg::REQ_CHECK, 16'd0, 32'd0, 24'd0, 32'd101);
		set_config(24'hFFFFFF, 5'd0);
		tx_gap_mode = GAP_HEAVY;
		rx_stall_mode = GAP_HEAVY;
		for (int i = 0; i < DEPTH + 1; i++)
			send_req(selt_pkg::REQ_CHECK, 16'd0, 32'd0, 24'hFFFFFE, 32'd101);
	endtask

	task automatic test_backpressure();
		set_config(selt_pkg::THRESHOLD_RESET, selt_pkg::MAX_SUSP_RESET);
		tx_gap_mode = GAP_NONE;
		rx_stall_mode = GAP_NONE;
		rx_hold = 300;
		for (int i = 0; i < 40; i++) send_random_req();
	endtask

	task automatic test_random_traffic();
		logic [23:0] thr_set [6];
		logic [4:0]  susp_set [6];
		thr_set = '{selt_pkg::THRESHOLD_RESET, 24'd0, 24'hFFFFFF, 24'hFFFFFF,
			24'($urandom), 24'h100000};
		susp_set = '{selt_pkg::MAX_SUSP_RESET, 5'd0, 5'd0, 5'd16,
			5'($urandom_range(0, 16)), 5'd1};
		for (int p = 0; p < 6; p++) begin
			set_config(thr_set[p], susp_set[p]);
			tx_gap_mode = p % 3;
			rx_stall_mode = (p + 1) % 3;
			for (int i = 0; i < 190; i++) send_random_req();
		end
	endtask

	initial begin : main
		int k;
		for (int i = 0; i < DEPTH; i++) begin
			tbl_id[i] = '0;
			tbl_handle[i] = '0;
			tbl_susp[i] = 1'b0;
			tbl_stamp[i] = '0;
		end
		tbl_count = 0;
		cur_valid = 1'b0;
		cur_slot = 0;
		cfg_threshold = selt_pkg::THRESHOLD_RESET;
		cfg_max_susp = selt_pkg::MAX_SUSP_RESET;
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hFFFF;
		id_pool[2] = 16'h5555;
		id_pool[3] = 16'hAAAA;
		for (int i = 4; i < POOL_SIZE; i++) id_pool[i] = 16'($urandom);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_capacity();
		test_backpressure();
		test_random_traffic();

		in_valid <= 1'b0;
		for (k = 0; k < 20000 && pending_results.size() > 0; k++) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			errors++;
		end
		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule
